// ===== src/weekly_recurrence_match_top_defines.svh =====
// assertion macros for the weekly recurrence match block
// used by weekly_recurrence_match_top; expects clk_i and rst_ni in scope
`ifndef WEEKLY_RECURRENCE_MATCH_TOP_DEFINES_SVH
`define WEEKLY_RECURRENCE_MATCH_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define WRM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wrm: same-cycle check failed");

// next-cycle implication, off during reset
`define WRM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wrm: next-cycle check failed");

`endif

// ===== src/wrm_pkg.sv =====
// shared widths, register indexes, tables and types of the recurrence matcher
// no dependencies
`default_nettype none

package wrm_pkg;

  localparam int YearW    = 14;
  localparam int MonthW   = 4;
  localparam int DayW     = 5;
  localparam int WdayW    = 3;
  localparam int IvW      = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 14;
  localparam int DateW    = YearW + MonthW + DayW;

  // day count datapath
  localparam int YyW         = YearW + 1;
  localparam int DoyW        = 9;
  localparam int DnW         = 23;
  localparam int NumDnStages = 3;
  localparam int DaysPerYear = 365;
  localparam int YearBias    = 400;
  localparam int WdnBias     = 2;
  localparam int DaysPerWeek = 7;
  localparam int Div25Mul    = 2622;
  localparam int Div25Shift  = 16;
  localparam int Div25InW    = 13;
  localparam int Div25OutW   = 9;
  localparam int Div25ProdW  = Div25InW + 12;

  // remainder chain: one cell per bit of the day difference
  localparam int NumCells = DnW;
  localparam int RemW     = 11;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegStartYear     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStartMonth    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegStartDay      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegEndYear       = 3'd3;
  localparam logic [CfgIdxW-1:0] RegEndMonth      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegEndDay        = 3'd5;
  localparam logic [CfgIdxW-1:0] RegTargetWeekday = 3'd6;
  localparam logic [CfgIdxW-1:0] RegIntervalWeeks = 3'd7;

  // days from march 1 to the first of the month, march-based year
  localparam logic [DoyW-1:0] DoyBase [16] = '{
    9'd275, 9'd306, 9'd337, 9'd0,   9'd31,  9'd61,  9'd92,  9'd122,
    9'd153, 9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337, 9'd0
  };

  typedef struct packed {
    logic             hit;
    logic             neg;
    logic [DnW-1:0]   diff;
    logic [DnW-1:0]   wdn;
    logic [RemW-1:0]  rem_w;
    logic [WdayW-1:0] rem_d;
  } wrm_word_t;

  // exact floor(x / 25) for x below 4681
  function automatic logic [Div25OutW-1:0] div25(input logic [Div25InW-1:0] x);
    logic [Div25ProdW-1:0] p;
    p = Div25ProdW'(x) * Div25ProdW'(Div25Mul);
    return p[Div25Shift +: Div25OutW];
  endfunction

endpackage

`default_nettype wire

// ===== src/wrm_query_if.sv =====
// query channel: valid/ready handshake carrying one calendar date
// depends on wrm_pkg
`default_nettype none

interface wrm_query_if;
  import wrm_pkg::*;

  logic              valid;
  logic              ready;
  logic [YearW-1:0]  query_year;
  logic [MonthW-1:0] query_month;
  logic [DayW-1:0]   query_day;

  modport source (output valid, output query_year, output query_month,
                  output query_day, input ready);
  modport sink   (input valid, input query_year, input query_month,
                  input query_day, output ready);
endinterface

`default_nettype wire

// ===== src/wrm_result_if.sv =====
// result channel: valid/ready handshake carrying the match flag
// no dependencies
`default_nettype none

interface wrm_result_if;
  logic valid;
  logic ready;
  logic occurs;

  modport source (output valid, output occurs, input ready);
  modport sink   (input valid, input occurs, output ready);
endinterface

`default_nettype wire

// ===== src/weekly_recurrence_match_top.sv =====
// Weekly recurrence matcher: one date in, one match flag out, one word per
// clock cycle sustained while the result side is ready. A date passes the
// day count stages, a stage forming the day difference from the start date,
// 23 remainder cells (one per bit of the 23-bit day number, each reducing by
// seven and by seven times the interval), and the output register. Every
// stage holds its word only while the next one is full, so dates keep
// flowing into empty slots while a result waits to be taken. Configuration
// is written through cfg_wdata_i / cfg_idx_i / cfg_we_i; the user must
// write it only while the block holds no word (the block does not check).
// Depends on wrm_pkg, wrm_query_if, wrm_result_if, wrm_daynum, wrm_cell.
`default_nettype none
`include "weekly_recurrence_match_top_defines.svh"

module weekly_recurrence_match_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wrm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [wrm_pkg::CfgDataW-1:0]   cfg_wdata_i,
  wrm_query_if.sink                      query_i,
  wrm_result_if.source                   result_o
);
  import wrm_pkg::*;

  // configuration registers
  logic [YearW-1:0]  start_year_q, end_year_q;
  logic [MonthW-1:0] start_month_q, end_month_q;
  logic [DayW-1:0]   start_day_q, end_day_q;
  logic [WdayW-1:0]  target_q;
  logic [IvW-1:0]    interval_q;
  logic [RemW-1:0]   div_d, div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_year_q  <= '0;
      start_month_q <= MonthW'(1);
      start_day_q   <= DayW'(1);
      end_year_q    <= '0;
      end_month_q   <= MonthW'(1);
      end_day_q     <= DayW'(1);
      target_q      <= '0;
      interval_q    <= IvW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegStartYear:     start_year_q  <= cfg_wdata_i[YearW-1:0];
        RegStartMonth:    start_month_q <= cfg_wdata_i[MonthW-1:0];
        RegStartDay:      start_day_q   <= cfg_wdata_i[DayW-1:0];
        RegEndYear:       end_year_q    <= cfg_wdata_i[YearW-1:0];
        RegEndMonth:      end_month_q   <= cfg_wdata_i[MonthW-1:0];
        RegEndDay:        end_day_q     <= cfg_wdata_i[DayW-1:0];
        RegTargetWeekday: target_q      <= cfg_wdata_i[WdayW-1:0];
        RegIntervalWeeks: interval_q    <= cfg_wdata_i[IvW-1:0];
        default: ;
      endcase
    end
  end

  // whole weeks are a multiple of the interval when the day difference
  // modulo seven intervals is below seven
  assign div_d = {interval_q, 3'b000} - {3'b000, interval_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= RemW'(DaysPerWeek);
    end else begin
      div_q <= div_d;
    end
  end

  // range test on raw fields, year then month then day
  logic [DateW-1:0] s_cat, e_cat, q_cat;
  logic             hit_d;

  assign s_cat = {start_year_q, start_month_q, start_day_q};
  assign e_cat = {end_year_q, end_month_q, end_day_q};
  assign q_cat = {query_i.query_year, query_i.query_month, query_i.query_day};
  assign hit_d = (start_year_q != '0) && (end_year_q != '0)
              && (s_cat <= q_cat) && (q_cat <= e_cat);

  // front stages: three day count stages and the difference stage
  localparam int NumFront = NumDnStages + 1;

  logic [NumFront-1:0]    v_q, stg_rdy;
  logic [NumDnStages-1:0] hit_q;
  logic [DnW-1:0]         qdn, sdn;
  logic [DnW:0]           diff_full;
  wrm_word_t              p4_word_q;

  logic                   cell_v   [NumCells+1];
  wrm_word_t              cell_w   [NumCells+1];
  logic                   cell_rdy [NumCells+1];
  logic                   out_rdy;

  always_comb begin
    stg_rdy[NumFront-1] = !v_q[NumFront-1] || cell_rdy[0];
    for (int k = NumFront - 2; k >= 0; k--) begin
      stg_rdy[k] = !v_q[k] || stg_rdy[k+1];
    end
  end

  assign query_i.ready = stg_rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (stg_rdy[0]) begin
        v_q[0] <= query_i.valid;
      end
      for (int k = 1; k < NumFront; k++) begin
        if (stg_rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  wrm_daynum u_query_dn (
    .clk_i   (clk_i),
    .adv_i   (stg_rdy[NumDnStages-1:0]),
    .year_i  (query_i.query_year),
    .month_i (query_i.query_month),
    .day_i   (query_i.query_day),
    .dn_o    (qdn)
  );

  // start day count follows the configuration registers
  wrm_daynum u_start_dn (
    .clk_i   (clk_i),
    .adv_i   ('1),
    .year_i  (start_year_q),
    .month_i (start_month_q),
    .day_i   (start_day_q),
    .dn_o    (sdn)
  );

  assign diff_full = {1'b0, qdn} - {1'b0, sdn};

  always_ff @(posedge clk_i) begin
    if (stg_rdy[0]) begin
      hit_q[0] <= hit_d;
    end
    for (int k = 1; k < NumDnStages; k++) begin
      if (stg_rdy[k]) begin
        hit_q[k] <= hit_q[k-1];
      end
    end
    if (stg_rdy[NumFront-1]) begin
      p4_word_q.hit   <= hit_q[NumDnStages-1];
      p4_word_q.neg   <= diff_full[DnW];
      p4_word_q.diff  <= diff_full[DnW-1:0];
      p4_word_q.wdn   <= qdn + DnW'(WdnBias);
      p4_word_q.rem_w <= '0;
      p4_word_q.rem_d <= '0;
    end
  end

  assign cell_v[0] = v_q[NumFront-1];
  assign cell_w[0] = p4_word_q;

  // remainder chain
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    wrm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .div_i       (div_q),
      .in_valid_i  (cell_v[i]),
      .in_word_i   (cell_w[i]),
      .in_ready_o  (cell_rdy[i]),
      .out_valid_o (cell_v[i+1]),
      .out_word_o  (cell_w[i+1]),
      .out_ready_i (cell_rdy[i+1])
    );
  end

  // output register
  wrm_word_t last_w;
  logic      wday_ok, week_ok, occurs_d;
  logic      ov_q, occurs_q;

  assign last_w   = cell_w[NumCells];
  assign wday_ok  = (last_w.rem_d == target_q);
  assign week_ok  = (interval_q <= IvW'(1))
                 || (!last_w.neg && (last_w.rem_w < RemW'(DaysPerWeek)));
  assign occurs_d = last_w.hit && wday_ok && week_ok;

  assign out_rdy            = !ov_q || result_o.ready;
  assign cell_rdy[NumCells] = out_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_rdy) begin
      ov_q <= cell_v[NumCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && cell_v[NumCells]) begin
      occurs_q <= occurs_d;
    end
  end

  assign result_o.valid  = ov_q;
  assign result_o.occurs = occurs_q;

  // checks
  `WRM_ASSERT_IMPL(a_ready_when_free, !v_q[0], query_i.ready)
  `WRM_ASSERT_IMPL(a_occurs_needs_rule, result_o.valid && result_o.occurs, start_year_q != '0 && end_year_q != '0)
  `WRM_ASSERT_NEXT(a_result_lands, cell_v[NumCells] && out_rdy, result_o.valid)

endmodule

`default_nettype wire

// ===== src/wrm_daynum.sv =====
// three-stage linear day count of the proleptic gregorian calendar
// depends on wrm_pkg
`default_nettype none

module wrm_daynum (
  input  logic                         clk_i,
  input  logic [wrm_pkg::NumDnStages-1:0] adv_i,
  input  logic [wrm_pkg::YearW-1:0]    year_i,
  input  logic [wrm_pkg::MonthW-1:0]   month_i,
  input  logic [wrm_pkg::DayW-1:0]     day_i,
  output logic [wrm_pkg::DnW-1:0]      dn_o
);
  import wrm_pkg::*;

  logic                  jan_feb;
  logic [YyW-1:0]        yy_d, yy_q;
  logic [DoyW-1:0]       doy_d, doy_q, doy2_q;
  logic [DnW:0]          y365_prod;
  logic [DnW-1:0]        y365_q;
  logic [Div25InW-1:0]   y4_d, y4_q;
  logic [Div25OutW-1:0]  y100_q, y400_q;
  logic [DnW-1:0]        dn_d, dn_q;

  // stage 1: march-based year and day of year
  always_comb begin
    jan_feb = (month_i <= 4'd2);
    yy_d    = YyW'(year_i) + YyW'(YearBias) - YyW'(jan_feb);
    doy_d   = DoyBase[month_i] + DoyW'(day_i);
  end

  // stage 2: year terms
  assign y365_prod = (DnW+1)'(yy_q) * (DnW+1)'(DaysPerYear);
  assign y4_d      = yy_q[YyW-1:2];

  // stage 3: sum of terms
  assign dn_d = y365_q + DnW'(y4_q) - DnW'(y100_q) + DnW'(y400_q) + DnW'(doy2_q);

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      yy_q  <= yy_d;
      doy_q <= doy_d;
    end
    if (adv_i[1]) begin
      y365_q <= y365_prod[DnW-1:0];
      y4_q   <= y4_d;
      y100_q <= div25(y4_d);
      y400_q <= div25(Div25InW'(yy_q[YyW-1:4]));
      doy2_q <= doy_q;
    end
    if (adv_i[2]) begin
      dn_q <= dn_d;
    end
  end

  assign dn_o = dn_q;

endmodule

`default_nettype wire

// ===== src/wrm_cell.sv =====
// one cell of the remainder chain: takes the top bit of the day difference
// and of the biased day number into two running remainders; depends on wrm_pkg
`default_nettype none

module wrm_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [wrm_pkg::RemW-1:0] div_i,
  input  logic                  in_valid_i,
  input  wrm_pkg::wrm_word_t    in_word_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  output wrm_pkg::wrm_word_t    out_word_o,
  input  logic                  out_ready_i
);
  import wrm_pkg::*;

  logic             valid_q;
  wrm_word_t        word_d, word_q;
  logic [RemW:0]    rw;
  logic [WdayW:0]   rd;

  always_comb begin
    rw = {in_word_i.rem_w, in_word_i.diff[DnW-1]};
    if (rw >= {1'b0, div_i}) begin
      rw = rw - {1'b0, div_i};
    end
    rd = {in_word_i.rem_d, in_word_i.wdn[DnW-1]};
    if (rd >= (WdayW+1)'(DaysPerWeek)) begin
      rd = rd - (WdayW+1)'(DaysPerWeek);
    end
    word_d       = in_word_i;
    word_d.rem_w = rw[RemW-1:0];
    word_d.rem_d = rd[WdayW-1:0];
    word_d.diff  = {in_word_i.diff[DnW-2:0], 1'b0};
    word_d.wdn   = {in_word_i.wdn[DnW-2:0], 1'b0};
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

`default_nettype wire

// ===== tb/weekly_recurrence_match_top_tb.sv =====
// testbench for weekly_recurrence_match_top: runs dates through a series of rules
// and checks each match flag in order against a predictor of the rule
// depends on wrm_pkg, wrm_query_if, wrm_result_if and the top module

module weekly_recurrence_match_top_tb;
  import wrm_pkg::*;

  localparam logic [WdayW-1:0] NoWeekday = 3'd7;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } date_t;

  typedef struct {
    date_t            start_date;
    date_t            end_date;
    logic [WdayW-1:0] weekday;
    logic [IvW-1:0]   interval;
  } rule_t;

  // predicted match flags, checked in order of the accepted dates
  class occurrence_book;
    rule_t rule;
    logic  expected_flags[$];
    int    mismatches;

    function new();
      rule.start_date = '{year: '0, month: 4'd1, day: 5'd1};
      rule.end_date   = '{year: '0, month: 4'd1, day: 5'd1};
      rule.weekday    = '0;
      rule.interval   = 8'd1;
      mismatches      = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegStartYear:     rule.start_date.year  = data[YearW-1:0];
        RegStartMonth:    rule.start_date.month = data[MonthW-1:0];
        RegStartDay:      rule.start_date.day   = data[DayW-1:0];
        RegEndYear:       rule.end_date.year    = data[YearW-1:0];
        RegEndMonth:      rule.end_date.month   = data[MonthW-1:0];
        RegEndDay:        rule.end_date.day     = data[DayW-1:0];
        RegTargetWeekday: rule.weekday          = data[WdayW-1:0];
        RegIntervalWeeks: rule.interval         = data[IvW-1:0];
        default: ;
      endcase
    endfunction

    // linear day count from march 1 of year -400, plus one; out-of-range
    // days and months 0, 13 and 14 simply count on; month 15 counts as march
    static function longint day_count(date_t dt);
      longint yy, cyc, yoc, mp, doy;
      yy  = longint'(dt.year) + YearBias - ((dt.month <= 2) ? 1 : 0);
      cyc = yy / YearBias;
      yoc = yy - cyc * YearBias;
      mp  = (longint'(dt.month) + 9) % 12;
      doy = (153 * mp + 2) / 5 + longint'(dt.day);
      return cyc * 146097 + yoc * DaysPerYear + yoc / 4 - yoc / 100 + doy;
    endfunction

    // raw field-by-field compare, no calendar check
    static function bit not_after(date_t a, date_t b);
      if (a.year != b.year) return a.year < b.year;
      if (a.month != b.month) return a.month < b.month;
      return a.day <= b.day;
    endfunction

    function logic fires_on(date_t q);
      longint qdays, sdays;
      if (rule.start_date.year == 0 || rule.end_date.year == 0) return 1'b0;
      if (!not_after(rule.start_date, q) || !not_after(q, rule.end_date)) return 1'b0;
      qdays = day_count(q);
      if ((qdays + WdnBias) % DaysPerWeek != rule.weekday) return 1'b0;
      if (rule.interval <= 1) return 1'b1;
      sdays = day_count(rule.start_date);
      // start date that counts past the query never fires
      if (qdays < sdays) return 1'b0;
      return ((qdays - sdays) / DaysPerWeek) % rule.interval == 0;
    endfunction

    function void note_date(date_t q);
      expected_flags.push_back(fires_on(q));
    endfunction

    function void check_flag(logic occurs);
      logic want;
      if (expected_flags.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with no date pending, occurs=%0b", $time, occurs);
        return;
      end
      want = expected_flags.pop_front();
      if (occurs !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: occurs mismatch, expected %0b, got %0b", $time, want, occurs);
      end
    endfunction

    function int pending();
      return expected_flags.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  wrm_query_if  query_bus ();
  wrm_result_if result_bus ();

  occurrence_book book;
  bit             idle_on;
  bit             long_hold_req;

  weekly_recurrence_match_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .query_i     (query_bus),
    .result_o    (result_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic date_t mk_date(int y, int m, int d);
    return '{year: YearW'(y), month: MonthW'(m), day: DayW'(d)};
  endfunction

  function automatic rule_t make_rule(int sy, int sm, int sd, int ey, int em, int ed,
                                      int wd, int iv);
    rule_t r;
    r.start_date = mk_date(sy, sm, sd);
    r.end_date   = mk_date(ey, em, ed);
    r.weekday    = WdayW'(wd);
    r.interval   = IvW'(iv);
    return r;
  endfunction

  // inverse of the day count, always gives a valid calendar date
  function automatic date_t date_from_days(longint dn);
    longint z, era, doe, yoe, doy, mp, mon;
    date_t  dt;
    z   = dn - 1;
    era = z / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    mon = (mp < 10) ? mp + 3 : mp - 9;
    dt.day   = DayW'(doy - (153 * mp + 2) / 5 + 1);
    dt.month = MonthW'(mon);
    dt.year  = YearW'(yoe + era * 400 - YearBias + ((mon <= 2) ? 1 : 0));
    return dt;
  endfunction

  // mostly dates inside the rule window on its weekday and week grid,
  // the rest near the boundaries or raw field noise
  function automatic date_t pick_query(rule_t r);
    longint a, b, lo, hi, base, step, dn, min_days, max_days;
    int unsigned kind, wd;
    min_days = occurrence_book::day_count(mk_date(0, 1, 1));
    max_days = occurrence_book::day_count(mk_date(16383, 12, 31));
    a  = occurrence_book::day_count(r.start_date);
    b  = occurrence_book::day_count(r.end_date);
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (lo < min_days) lo = min_days;
    if (hi > max_days) hi = max_days;
    if (lo > hi) lo = hi;
    wd   = r.weekday % DaysPerWeek;
    base = lo + (wd + DaysPerWeek - (lo + WdnBias) % DaysPerWeek) % DaysPerWeek;
    step = DaysPerWeek * ((r.interval > 1) ? r.interval : 1);
    kind = $urandom_range(0, 99);
    if (kind < 45)
      dn = base + step * $urandom_range(0, (hi >= base) ? int'((hi - base) / step) : 0);
    else if (kind < 60)
      dn = base + DaysPerWeek *
           $urandom_range(0, (hi >= base) ? int'((hi - base) / DaysPerWeek) : 0);
    else if (kind < 80)
      dn = lo - 14 + $urandom_range(0, int'(hi - lo + 28));
    else if (kind < 90) begin
      case ($urandom_range(0, 3))
        0: dn = lo - 1;
        1: dn = lo;
        2: dn = hi;
        default: dn = hi + 1;
      endcase
    end else
      return date_t'($urandom);
    if (dn < min_days) dn = min_days;
    if (dn > max_days) dn = max_days;
    return date_from_days(dn);
  endfunction

  function automatic rule_t random_rule();
    rule_t r;
    longint lo, hi, s, e;
    int unsigned pick;
    lo = occurrence_book::day_count(mk_date(1601, 1, 1));
    hi = occurrence_book::day_count(mk_date(9999, 12, 31));
    s  = lo + $urandom_range(0, int'(hi - lo));
    case ($urandom_range(0, 2))
      0: e = s + $urandom_range(0, 400);
      1: e = s + $urandom_range(0, 8000);
      default: e = s + $urandom_range(0, 400000);
    endcase
    if (e > hi) e = hi;
    r.start_date = date_from_days(s);
    r.end_date   = date_from_days(e);
    pick = $urandom_range(0, 19);
    if (pick == 0) r.interval = '0;
    else if (pick < 10) r.interval = IvW'($urandom_range(1, 4));
    else r.interval = IvW'($urandom_range(5, 255));
    r.weekday = ($urandom_range(0, 13) == 0) ? NoWeekday : WdayW'($urandom_range(0, 6));
    return r;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    book.set_reg(idx, data);
  endtask

  // drop valid and hold until every expected flag has come back
  task automatic wait_drained();
    @(negedge clk_i);
    query_bus.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
  endtask

  task automatic apply_rule(rule_t r);
    wait_drained();
    write_reg(RegStartYear,     CfgDataW'(r.start_date.year));
    write_reg(RegStartMonth,    CfgDataW'(r.start_date.month));
    write_reg(RegStartDay,      CfgDataW'(r.start_date.day));
    write_reg(RegEndYear,       CfgDataW'(r.end_date.year));
    write_reg(RegEndMonth,      CfgDataW'(r.end_date.month));
    write_reg(RegEndDay,        CfgDataW'(r.end_date.day));
    write_reg(RegTargetWeekday, CfgDataW'(r.weekday));
    write_reg(RegIntervalWeeks, CfgDataW'(r.interval));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    // wait for the start day count to settle after the last write
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send_query(date_t q);
    int gap;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      query_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    query_bus.valid       <= 1'b1;
    query_bus.query_year  <= q.year;
    query_bus.query_month <= q.month;
    query_bus.query_day   <= q.day;
    do @(posedge clk_i); while (!query_bus.ready);
    book.note_date(q);
  endtask

  task automatic send_random(rule_t r, int count);
    repeat (count) send_query(pick_query(r));
  endtask

  // result side: random stall bursts, plus one long hold on request
  initial begin
    int stall_left;
    stall_left = 0;
    result_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = 150;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0)
        stall_left = $urandom_range(1, 5);
      if (stall_left > 0) begin
        result_bus.ready <= 1'b0;
        stall_left--;
      end else
        result_bus.ready <= 1'b1;
      @(posedge clk_i);
      if (result_bus.valid && result_bus.ready) book.check_flag(result_bus.occurs);
    end
  end

  initial begin
    rule_t r;
    book = new();
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = RegStartYear;
    cfg_wdata_i           = '0;
    query_bus.valid       = 1'b0;
    query_bus.query_year  = '0;
    query_bus.query_month = '0;
    query_bus.query_day   = '0;
    idle_on               = 1'b1;
    long_hold_req         = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // rule unset after reset, never fires
    send_query(mk_date(2024, 1, 7));
    send_query(mk_date(9999, 12, 31));

    // every other saturday from 2000-01-01
    r = make_rule(2000, 1, 1, 2030, 12, 31, 6, 2);
    apply_rule(r);
    send_query(mk_date(2000, 1, 1));
    send_query(mk_date(2000, 1, 8));
    send_query(mk_date(2000, 1, 15));
    send_query(mk_date(1999, 12, 31));
    send_query(mk_date(2030, 12, 28));
    send_query(mk_date(2031, 1, 4));
    send_query(mk_date(2000, 2, 29));
    send_query(mk_date(2001, 2, 31));
    send_query(mk_date(2010, 0, 5));
    send_query(mk_date(2010, 13, 1));
    send_query(mk_date(2010, 15, 31));
    send_query(mk_date(2010, 5, 0));
    send_query(mk_date(0, 0, 0));
    send_query(mk_date(16383, 15, 31));
    send_query(mk_date(1601, 1, 1));
    send_query(mk_date(8192, 1, 1));
    wait_drained();
    send_random(r, 50);

    // start year unset
    r = make_rule(0, 1, 1, 9999, 12, 31, 0, 1);
    apply_rule(r);
    send_random(r, 50);

    // end year unset, odd start fields
    r = make_rule(1601, 15, 31, 0, 0, 0, 4, 1);
    apply_rule(r);
    send_random(r, 50);

    // wide window, longest interval; result side holds off for a while
    r = make_rule(1601, 1, 1, 9999, 12, 31, 0, 255);
    apply_rule(r);
    long_hold_req = 1'b1;
    send_random(r, 50);

    // weekday seven never fires
    r = make_rule(2024, 2, 29, 2026, 3, 1, NoWeekday, 3);
    apply_rule(r);
    send_random(r, 50);

    // interval zero fires every week
    r = make_rule(2024, 2, 29, 2026, 3, 1, 3, 0);
    apply_rule(r);
    send_random(r, 50);

    // start month 13 counts on to 2021-01-31, past early january queries
    r = make_rule(2020, 13, 31, 2021, 12, 31, 0, 2);
    apply_rule(r);
    send_query(mk_date(2021, 1, 3));
    send_query(mk_date(2021, 1, 31));
    send_query(mk_date(2021, 2, 7));
    send_query(mk_date(2021, 2, 14));
    send_random(r, 50);

    // register field extremes
    r = make_rule(1, 0, 0, 16383, 15, 31, 5, 128);
    apply_rule(r);
    send_random(r, 50);

    for (int p = 0; p < 10; p++) begin
      r = random_rule();
      idle_on = (p == 9) ? 1'b0 : ($urandom_range(0, 4) != 0);
      apply_rule(r);
      send_random(r, 155);
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (book.mismatches == 0 && book.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/wrm_pkg.sv
src/wrm_query_if.sv
src/wrm_result_if.sv
src/wrm_daynum.sv
src/wrm_cell.sv
src/weekly_recurrence_match_top.sv
tb/weekly_recurrence_match_top_tb.sv
